[sv/assert_macros.svh]
// Assertion macros for the checker file of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold on the cycle after the antecedent, outside reset.
`define FET_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("next-cycle property failed");

// The expression must hold at every clock edge, outside reset.
`define FET_ASSERT_ALWAYS(lbl, ck, rs, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (cons)) \
    else $error("invariant property failed");

// The consequent must hold on the cycle after reset is sampled high.
`define FET_ASSERT_AFTER_RESET(lbl, ck, rs, cons) \
  lbl: assert property (@(posedge ck) (rs) |=> (cons)) \
    else $error("post-reset property failed");

`endif

[sv/fet_pkg.sv]
// Shared types, constants and unit-scaling functions of the extent translator.
package fet_pkg;

  // Size of the extent table and the physical block size.
  localparam int MAX_EXTENTS = 8;
  localparam int PHYS_LOG2   = 9;
  localparam int EXT_IDX_W   = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
  localparam int ENTRY_W     = 64;

  // Depth of the command queue between the front and the back.
  localparam int CMD_QUEUE_DEPTH = 4;

  // Shift amounts are carried as six-bit values.
  localparam logic [5:0] PHYS_LG = 6'(PHYS_LOG2);

  // Request opcodes.
  localparam logic [1:0] OP_WRITE_EXTENT = 2'd0;
  localparam logic [1:0] OP_AREA_TO_PHYS = 2'd1;
  localparam logic [1:0] OP_PHYS_TO_AREA = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_ROOT_MODE      = 2'd0;
  localparam logic [1:0] CFG_AREA_LOG2      = 2'd1;
  localparam logic [1:0] CFG_FRAGMENT_LOG2  = 2'd2;
  localparam logic [1:0] CFG_HEADER_BASE    = 2'd3;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] lookup_block;
    logic [2:0]  entry_index;
    logic [31:0] extent_start;
    logic [31:0] extent_length;
  } req_t;

  typedef struct packed {
    logic [31:0] translated_block;
    logic        used_fallback;
  } rsp_t;

  typedef struct packed {
    logic        root_mode;
    logic [4:0]  area_block_log2;
    logic [4:0]  fragment_block_log2;
    logic [31:0] header_base;
  } cfg_t;

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_FORWARD,
    CMD_REVERSE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t              kind;
    logic [31:0]            lookup_block;
    logic [EXT_IDX_W-1:0]   slot;
    logic [31:0]            extent_start;
    logic [31:0]            extent_length;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SETUP,
    BK_SCAN,
    BK_DIRECT,
    BK_JOIN,
    BK_SCALE
  } back_state_t;

  // Widen a five-bit log2 value to a shift amount.
  function automatic logic [5:0] lg6(input logic [4:0] l);
    return {1'b0, l};
  endfunction

  // Shifts that give zero for amounts of 32 or more.
  function automatic logic [31:0] shl32(input logic [31:0] x, input logic [5:0] s);
    return (s >= 6'd32) ? 32'd0 : (x << s);
  endfunction

  function automatic logic [31:0] shr32(input logic [31:0] x, input logic [5:0] s);
    return (s >= 6'd32) ? 32'd0 : (x >> s);
  endfunction

  function automatic logic [31:0] low_mask(input logic [5:0] s);
    return ~shl32(32'hFFFF_FFFF, s);
  endfunction

  // Convert a count from units of 2^up to units of 2^down, expressed as a
  // left shift by (up - down) when up >= down, and a right shift otherwise.
  function automatic logic [31:0] rescale(input logic [31:0] x, input logic [5:0] up,
                                          input logic [5:0] down);
    if (up >= down) begin
      return shl32(x, up - down);
    end
    return shr32(x, down - up);
  endfunction

endpackage

[sv/fragment_extent_translator_core.sv]
// Top level of the fragment extent translator.
// Translates block numbers between an area's logical space and physical
// storage through a table of up to MAX_EXTENTS extents (start and length in
// fragment blocks, ended by the first zero length, cleared at reset). Opcode 0
// writes one table slot, opcode 1 maps an area block to a physical block and
// opcode 2 maps a physical block back; opcode 3 is dropped without a result.
// Requests pass through a four-entry command queue to a sequencer that walks
// the table one extent per cycle from a RAM with registered read. A table
// write is taken by the sequencer in its idle state; a translation passes
// through a setup step, the extent walk (skipped in root mode or with
// no fragment size), a join or a direct step and a scaling step. The
// extent walk sets the rate. Results sit in an output register, so the next
// request is worked on while a finished result waits. Configuration writes
// are always accepted and must only be made while no request is in flight.
module fragment_extent_translator_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  fet_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output fet_pkg::rsp_t rsp,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [31:0]   cfg_data
);

  import fet_pkg::*;

  cfg_t cfg;
  cmd_t push_cmd;
  cmd_t head;
  logic push;
  logic queue_full;
  logic q_empty;
  logic pop;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.root_mode           <= 1'b0;
      cfg.area_block_log2     <= 5'd12;
      cfg.fragment_block_log2 <= 5'd0;
      cfg.header_base         <= 32'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ROOT_MODE:     cfg.root_mode           <= cfg_data[0];
        CFG_AREA_LOG2:     cfg.area_block_log2     <= cfg_data[4:0];
        CFG_FRAGMENT_LOG2: cfg.fragment_block_log2 <= cfg_data[4:0];
        CFG_HEADER_BASE:   cfg.header_base         <= cfg_data;
        default:           cfg.root_mode           <= cfg.root_mode;
      endcase
    end
  end

  // Front end: accept and classify.
  fet_front u_front (
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .queue_full (queue_full),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  // Command queue.
  fet_cmd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (queue_full),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty)
  );

  // Translation engine.
  fet_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .head      (head),
    .pop       (pop),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

[sv/fet_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module fet_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/fet_front.sv]
// Request front end: accepts transactions and turns them into queue commands.
module fet_front (
  input  logic          req_valid,
  output logic          req_stall,
  input  fet_pkg::req_t req,
  input  logic          queue_full,
  output logic          push,
  output fet_pkg::cmd_t push_cmd
);

  import fet_pkg::*;

  logic accept;
  logic keep;

  // A transaction waits only while the queue has no room.
  assign req_stall = queue_full;
  assign accept    = req_valid && !queue_full;

  // Classify the opcode; unused opcodes and writes beyond the table vanish here.
  always_comb begin
    push_cmd.lookup_block  = req.lookup_block;
    push_cmd.slot          = EXT_IDX_W'(req.entry_index);
    push_cmd.extent_start  = req.extent_start;
    push_cmd.extent_length = req.extent_length;
    push_cmd.kind          = CMD_WRITE;
    keep                   = 1'b0;
    case (req.opcode)
      OP_WRITE_EXTENT: begin
        push_cmd.kind = CMD_WRITE;
        keep          = (32'(req.entry_index) < MAX_EXTENTS);
      end
      OP_AREA_TO_PHYS: begin
        push_cmd.kind = CMD_FORWARD;
        keep          = 1'b1;
      end
      OP_PHYS_TO_AREA: begin
        push_cmd.kind = CMD_REVERSE;
        keep          = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign push = accept && keep;

endmodule

[sv/fet_cmd_queue.sv]
// Short command queue between the front end and the translation engine.
module fet_cmd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  fet_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output fet_pkg::cmd_t head,
  output logic          empty
);

  import fet_pkg::*;

  localparam int PTR_W = (CMD_QUEUE_DEPTH > 1) ? $clog2(CMD_QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(CMD_QUEUE_DEPTH + 1);

  cmd_t             slots [CMD_QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(CMD_QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr];

  // Pointers wrap at the queue depth.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(CMD_QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(CMD_QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

[sv/fet_back.sv]
// Translation engine: owns the extent table, walks it and drives the result.
module fet_back (
  input  logic          clk,
  input  logic          rst,
  input  fet_pkg::cfg_t cfg,
  input  logic          q_empty,
  input  fet_pkg::cmd_t head,
  output logic          pop,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output fet_pkg::rsp_t rsp
);

  import fet_pkg::*;

  localparam logic [EXT_IDX_W-1:0] LAST_IDX = EXT_IDX_W'(MAX_EXTENTS - 1);

  back_state_t            state;
  back_state_t            state_next;
  logic                   is_fwd;
  logic [31:0]            bn;
  logic [31:0]            key;
  logic [31:0]            frac_part;
  logic [31:0]            cum;
  logic [31:0]            rel;
  logic [31:0]            hit_start;
  logic [31:0]            pa;
  logic [31:0]            pb;
  logic                   fb;
  logic [EXT_IDX_W-1:0]   scan_idx;
  logic [MAX_EXTENTS-1:0] entry_valid;
  logic                   rd_valid;

  logic                   ram_we;
  logic [EXT_IDX_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0]     rd_data;
  logic                   out_load;

  logic [5:0]  a_lg;
  logic [5:0]  f_lg;
  logic        direct;
  logic [31:0] rd_start;
  logic [31:0] rd_len;
  logic        table_end;
  logic        hit;
  logic        last;

  assign a_lg   = lg6(cfg.area_block_log2);
  assign f_lg   = lg6(cfg.fragment_block_log2);
  assign direct = cfg.root_mode || (cfg.fragment_block_log2 == 5'd0);

  // Extent table: start in the upper half of a word, length in the lower half.
  fet_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_EXTENTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (head.slot),
    .wdata ({head.extent_start, head.extent_length}),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  // Entries never written since reset read as zero length.
  assign rd_start  = rd_data[ENTRY_W-1:32];
  assign rd_len    = rd_valid ? rd_data[31:0] : 32'd0;
  assign table_end = (rd_len == 32'd0);
  assign last      = (scan_idx == LAST_IDX);

  // Match test for the entry being examined.
  always_comb begin
    if (is_fwd) begin
      hit = key < (cum + rd_len);
    end else begin
      hit = (key >= rd_start) && (key < (rd_start + rd_len));
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (!q_empty && head.kind != CMD_WRITE) begin
          state_next = BK_SETUP;
        end
      end
      BK_SETUP: begin
        state_next = direct ? BK_DIRECT : BK_SCAN;
      end
      BK_SCAN: begin
        if (table_end) begin
          state_next = BK_DIRECT;
        end else if (hit) begin
          state_next = BK_JOIN;
        end else if (last) begin
          state_next = BK_DIRECT;
        end
      end
      BK_DIRECT: state_next = BK_SCALE;
      BK_JOIN:   state_next = BK_SCALE;
      BK_SCALE: begin
        if (out_load) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    pop       = 1'b0;
    ram_we    = 1'b0;
    ram_raddr = '0;
    out_load  = 1'b0;
    case (state)
      BK_IDLE: begin
        pop    = !q_empty;
        ram_we = !q_empty && (head.kind == CMD_WRITE);
      end
      BK_SCAN: begin
        ram_raddr = scan_idx + 1'b1;
      end
      BK_SCALE: begin
        out_load = !rsp_valid || !rsp_stall;
      end
      default: begin
        ram_raddr = '0;
      end
    endcase
  end

  // State register, table valid bits and result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= BK_IDLE;
      entry_valid <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (ram_we) begin
        entry_valid[head.slot] <= 1'b1;
      end
      if (out_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Valid bit travels alongside the registered table read.
  always_ff @(posedge clk) begin
    rd_valid <= entry_valid[ram_raddr];
  end

  // Datapath registers, one step of the translation per state.
  always_ff @(posedge clk) begin
    case (state)
      BK_IDLE: begin
        if (pop) begin
          is_fwd <= (head.kind == CMD_FORWARD);
          bn     <= head.lookup_block;
        end
      end
      BK_SETUP: begin
        cum      <= 32'd0;
        scan_idx <= '0;
        fb       <= 1'b0;
        if (is_fwd) begin
          key       <= rescale(bn, a_lg, f_lg);
          frac_part <= (a_lg >= f_lg) ? 32'd0 : (bn & low_mask(f_lg - a_lg));
        end else begin
          key       <= rescale(bn, PHYS_LG, f_lg);
          frac_part <= (f_lg >= PHYS_LG) ? (bn & low_mask(f_lg - PHYS_LG)) : 32'd0;
        end
      end
      BK_SCAN: begin
        if (table_end) begin
          // An empty table maps directly without raising the flag.
          fb <= (scan_idx != '0);
        end else if (hit) begin
          rel       <= is_fwd ? (key - cum) : (key - rd_start);
          hit_start <= rd_start;
        end else begin
          cum      <= cum + (is_fwd ? rd_len : rescale(rd_len, a_lg, f_lg));
          scan_idx <= scan_idx + 1'b1;
          fb       <= last;
        end
      end
      BK_DIRECT: begin
        if (is_fwd) begin
          pa <= cfg.root_mode ? 32'd0 : cfg.header_base;
          pb <= rescale(bn, a_lg, PHYS_LG);
        end else begin
          pa <= rescale(cfg.root_mode ? bn : (bn - cfg.header_base), PHYS_LG, a_lg);
          pb <= 32'd0;
        end
      end
      BK_JOIN: begin
        if (is_fwd) begin
          pa <= rescale(hit_start + rel, f_lg, PHYS_LG);
          pb <= rescale(frac_part, a_lg, PHYS_LG);
        end else begin
          if (a_lg >= f_lg) begin
            pa <= shl32(cum + rel, a_lg - f_lg);
          end else begin
            pa <= cum + shr32(rel, f_lg - a_lg);
          end
          pb <= rescale(frac_part, PHYS_LG, a_lg);
        end
      end
      BK_SCALE: begin
        if (out_load) begin
          rsp.translated_block <= pa + pb;
          rsp.used_fallback    <= fb;
        end
      end
      default: begin
        fb <= fb;
      end
    endcase
  end

endmodule

[sv/fet_checker.sv]
// Port-level checker for the extent translator, bound to the top level.
`include "assert_macros.svh"

module fet_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_stall,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input fet_pkg::rsp_t rsp,
  input logic          cfg_ready
);

  import fet_pkg::*;

  // A stalled result transaction stays offered and unchanged.
  `FET_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && rsp_stall, rsp_valid)
  `FET_ASSERT_NEXT(a_rsp_stable, clk, rst, rsp_valid && rsp_stall, $stable(rsp))

  // Reset empties the output register and the command queue.
  `FET_ASSERT_AFTER_RESET(a_rsp_reset, clk, rst, !rsp_valid)
  `FET_ASSERT_AFTER_RESET(a_req_reset, clk, rst, !req_stall)

  // Configuration writes are never held off.
  `FET_ASSERT_ALWAYS(a_cfg_ready, clk, rst, cfg_ready)

endmodule

bind fragment_extent_translator_core fet_checker u_fet_checker (
  .clk       (clk),
  .rst       (rst),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp),
  .cfg_ready (cfg_ready)
);

[tb/tb.sv]
// Testbench of the fragment extent translator: directed table, then random traffic.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fet_pkg::*;

  localparam int PHYS            = PHYS_LOG2;
  localparam int ITEMS_PER_BLOCK = 115;
  localparam int DRAIN_CYCLES    = 64;
  localparam int CYCLE_LIMIT     = 600000;

  // The opcode that the block drops without a result.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // One row of the directed table: either a register setting or a transaction.
  typedef struct {
    bit   is_setting;
    cfg_t setting;
    req_t r;
    bit   typed;
    rsp_t want;
  } step_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  req_t        req = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  rsp_t        rsp;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_ROOT_MODE;
  logic [31:0] cfg_data = '0;

  // Mirror of the block's registers and extent table.
  bit          map_root = 1'b0;
  int          map_area_lg = 12;
  int          map_frag_lg = 0;
  logic [31:0] map_header = '0;
  logic [31:0] extent_base [MAX_EXTENTS];
  logic [31:0] extent_span [MAX_EXTENTS];

  rsp_t        pending_translations[$];
  int          mismatches = 0;
  int          cycle_count = 0;
  int          req_idle_pct = 38;
  int          rsp_idle_pct = 88;
  bit          req_up = 1'b0;

  fragment_extent_translator_core u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Run limit: a hung block ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[fragment_extent_translator_core] ERROR");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
    mismatches++;
  endtask

  // Positive amounts shift left, negative ones right; 32 or more clears.
  function automatic logic [31:0] shift_by(input logic [31:0] x, input int sh);
    if (sh >= 32 || sh <= -32) return '0;
    if (sh >= 0) return x << sh;
    return x >> (-sh);
  endfunction

  function automatic logic [31:0] low_bits(input int s);
    if (s >= 32) return '1;
    return (32'd1 << s) - 32'd1;
  endfunction

  // Extents in use: those before the first zero length.
  function automatic int live_extents();
    int n;
    n = 0;
    while (n < MAX_EXTENTS && extent_span[n] != '0) n++;
    return n;
  endfunction

  // Area block to physical block.
  function automatic rsp_t area_to_phys(input logic [31:0] abn);
    rsp_t        o;
    int          n;
    int          s;
    logic [31:0] off;
    logic [31:0] frac_part;
    logic [31:0] acc;
    logic [31:0] span_end;
    logic [31:0] pf;
    o = '0;
    if (map_root) begin
      o.translated_block = shift_by(abn, map_area_lg - PHYS);
      return o;
    end
    n = live_extents();
    if (map_frag_lg == 0 || n == 0) begin
      o.translated_block = map_header + shift_by(abn, map_area_lg - PHYS);
      return o;
    end
    if (map_area_lg >= map_frag_lg) begin
      off = shift_by(abn, map_area_lg - map_frag_lg);
      frac_part = '0;
    end else begin
      s = map_frag_lg - map_area_lg;
      off = shift_by(abn, -s);
      frac_part = abn & low_bits(s);
    end
    // Walk the extents, summing lengths in fragment blocks.
    acc = '0;
    for (int i = 0; i < n; i++) begin
      span_end = acc + extent_span[i];
      if (off < span_end) begin
        pf = extent_base[i] + (off - acc);
        o.translated_block = shift_by(pf, map_frag_lg - PHYS)
                             + shift_by(frac_part, map_area_lg - PHYS);
        return o;
      end
      acc += extent_span[i];
    end
    o.used_fallback = 1'b1;
    o.translated_block = map_header + shift_by(abn, map_area_lg - PHYS);
    return o;
  endfunction

  // Physical block back to area block.
  function automatic rsp_t phys_to_area(input logic [31:0] pbn);
    rsp_t        o;
    int          n;
    int          s;
    logic [31:0] ps;
    logic [31:0] frac_part;
    logic [31:0] acc;
    logic [31:0] rel;
    logic [31:0] span_end;
    o = '0;
    if (map_root) begin
      o.translated_block = shift_by(pbn, PHYS - map_area_lg);
      return o;
    end
    n = live_extents();
    if (map_frag_lg == 0 || n == 0) begin
      o.translated_block = shift_by(pbn - map_header, PHYS - map_area_lg);
      return o;
    end
    if (map_frag_lg >= PHYS) begin
      s = map_frag_lg - PHYS;
      ps = shift_by(pbn, -s);
      frac_part = pbn & low_bits(s);
    end else begin
      ps = shift_by(pbn, PHYS - map_frag_lg);
      frac_part = '0;
    end
    // Search for the extent holding the fragment block; acc counts area blocks.
    acc = '0;
    for (int i = 0; i < n; i++) begin
      span_end = extent_base[i] + extent_span[i];
      if (ps >= extent_base[i] && ps < span_end) begin
        rel = ps - extent_base[i];
        if (map_area_lg >= map_frag_lg) begin
          o.translated_block = shift_by(acc + rel, map_area_lg - map_frag_lg);
        end else begin
          o.translated_block = acc + shift_by(rel, map_area_lg - map_frag_lg);
        end
        o.translated_block += shift_by(frac_part, PHYS - map_area_lg);
        return o;
      end
      acc += shift_by(extent_span[i], map_area_lg - map_frag_lg);
    end
    o.used_fallback = 1'b1;
    o.translated_block = shift_by(pbn - map_header, PHYS - map_area_lg);
    return o;
  endfunction

  // Applies one accepted transaction to the mirror and queues its result.
  task automatic predict_translation(input req_t r);
    case (r.opcode)
      OP_WRITE_EXTENT: begin
        if (r.entry_index < MAX_EXTENTS) begin
          extent_base[r.entry_index] = r.extent_start;
          extent_span[r.entry_index] = r.extent_length;
        end
      end
      OP_AREA_TO_PHYS: pending_translations.push_back(area_to_phys(r.lookup_block));
      OP_PHYS_TO_AREA: pending_translations.push_back(phys_to_area(r.lookup_block));
      default: ;
    endcase
  endtask

  function automatic void set_register(input logic [1:0] idx, input logic [31:0] data);
    case (idx)
      CFG_ROOT_MODE:     map_root = data[0];
      CFG_AREA_LOG2:     map_area_lg = int'(data[4:0]);
      CFG_FRAGMENT_LOG2: map_frag_lg = int'(data[4:0]);
      CFG_HEADER_BASE:   map_header = data;
      default: ;
    endcase
  endfunction

  task automatic lower_valid();
    if (req_up) begin
      req_valid <= 1'b0;
      req_up = 1'b0;
    end
  endtask

  // Offers one transaction, waits for it to be taken, then perhaps idles.
  task automatic drive_request(input req_t r, input bit typed, input rsp_t want);
    if (!req_up) begin
      req_valid <= 1'b1;
      req_up = 1'b1;
    end
    req <= r;
    do @(posedge clk); while (req_stall);
    if (typed) pending_translations.push_back(want);
    else predict_translation(r);
    if ($urandom_range(99) < req_idle_pct) begin
      lower_valid();
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic hold_until_quiet();
    lower_valid();
    do @(posedge clk); while (pending_translations.size() != 0);
  endtask

  // Waits for every result, then lets any queued table writes finish.
  task automatic settle();
    hold_until_quiet();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes all four registers in one burst.
  task automatic program_registers(input cfg_t c);
    logic [1:0]  regs [4];
    logic [31:0] vals [4];
    regs = '{CFG_ROOT_MODE, CFG_AREA_LOG2, CFG_FRAGMENT_LOG2, CFG_HEADER_BASE};
    vals = '{32'(c.root_mode), 32'(c.area_block_log2), 32'(c.fragment_block_log2),
             c.header_base};
    cfg_valid <= 1'b1;
    for (int k = 0; k < 4; k++) begin
      cfg_index <= regs[k];
      cfg_data <= vals[k];
      do @(posedge clk); while (!cfg_ready);
      set_register(regs[k], vals[k]);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic cfg_t make_setting(input bit root, input int area, input int frag,
                                        input logic [31:0] base);
    cfg_t c;
    c.root_mode = root;
    c.area_block_log2 = 5'(area);
    c.fragment_block_log2 = 5'(frag);
    c.header_base = base;
    return c;
  endfunction

  function automatic cfg_t random_setting();
    int area;
    int frag;
    area = ($urandom_range(9) == 0) ? $urandom_range(0, 31) : $urandom_range(9, 24);
    case ($urandom_range(9))
      0, 1:    frag = 0;
      2:       frag = $urandom_range(0, 31);
      default: frag = $urandom_range(1, 24);
    endcase
    return make_setting($urandom_range(7) == 0, area, frag, $urandom);
  endfunction

  function automatic step_t setting_step(input cfg_t c);
    step_t s;
    s = '{default: '0};
    s.is_setting = 1'b1;
    s.setting = c;
    return s;
  endfunction

  function automatic step_t request_step(input logic [1:0] op, input logic [31:0] bn,
                                         input logic [2:0] idx, input logic [31:0] st,
                                         input logic [31:0] len);
    step_t s;
    s = '{default: '0};
    s.r.opcode = op;
    s.r.lookup_block = bn;
    s.r.entry_index = idx;
    s.r.extent_start = st;
    s.r.extent_length = len;
    return s;
  endfunction

  function automatic step_t checked_step(input logic [1:0] op, input logic [31:0] bn,
                                         input logic [31:0] blk, input bit fb);
    step_t s;
    s = request_step(op, bn, 3'($urandom), $urandom, $urandom);
    s.typed = 1'b1;
    s.want.translated_block = blk;
    s.want.used_fallback = fb;
    return s;
  endfunction

  // Random contents in every field, with the block number often at an extreme.
  function automatic req_t random_fields();
    req_t r;
    r.opcode = 2'($urandom);
    case ($urandom_range(15))
      0:       r.lookup_block = '0;
      1:       r.lookup_block = '1;
      default: r.lookup_block = $urandom;
    endcase
    r.entry_index = 3'($urandom);
    r.extent_start = $urandom;
    r.extent_length = $urandom;
    return r;
  endfunction

  // An area block that falls inside a live extent where the scaling allows.
  function automatic logic [31:0] area_hit();
    int          n;
    int          i;
    logic [31:0] acc;
    logic [31:0] off;
    n = live_extents();
    if (n == 0) return $urandom;
    i = $urandom_range(0, n - 1);
    acc = '0;
    for (int j = 0; j < i; j++) acc += extent_span[j];
    off = acc + ($urandom % extent_span[i]);
    if (map_area_lg >= map_frag_lg) return shift_by(off, map_frag_lg - map_area_lg);
    return shift_by(off, map_area_lg - map_frag_lg)
           | ($urandom & low_bits(map_frag_lg - map_area_lg));
  endfunction

  // A physical block inside a live extent.
  function automatic logic [31:0] phys_hit();
    int          n;
    int          i;
    logic [31:0] ps;
    n = live_extents();
    if (n == 0) return $urandom;
    i = $urandom_range(0, n - 1);
    ps = extent_base[i] + ($urandom % extent_span[i]);
    if (map_frag_lg >= PHYS) begin
      return shift_by(ps, map_frag_lg - PHYS) | ($urandom & low_bits(map_frag_lg - PHYS));
    end
    return shift_by(ps, map_frag_lg - PHYS);
  endfunction

  // One block of random traffic: a fresh table, then mostly well-aimed lookups.
  task automatic run_block(input cfg_t c);
    req_t r;
    int   n;
    int   sel;
    settle();
    program_registers(c);
    n = $urandom_range(1, MAX_EXTENTS);
    for (int slot = 0; slot <= n && slot < MAX_EXTENTS; slot++) begin
      r = random_fields();
      r.opcode = OP_WRITE_EXTENT;
      r.entry_index = 3'(slot);
      r.extent_start = ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 32'h1FFFF);
      if (slot == n) r.extent_length = '0;
      else if ($urandom_range(9) == 0) r.extent_length = $urandom | 32'd1;
      else r.extent_length = $urandom_range(1, 64);
      drive_request(r, 1'b0, '0);
    end
    for (int k = n + 1; k < ITEMS_PER_BLOCK; k++) begin
      if (k == ITEMS_PER_BLOCK / 2) hold_until_quiet();
      r = random_fields();
      sel = $urandom_range(99);
      if (sel < 35) begin
        r.opcode = OP_AREA_TO_PHYS;
        r.lookup_block = area_hit();
      end else if (sel < 70) begin
        r.opcode = OP_PHYS_TO_AREA;
        r.lookup_block = phys_hit();
      end else if (sel < 80) begin
        r.opcode = OP_AREA_TO_PHYS;
      end else if (sel < 90) begin
        r.opcode = OP_PHYS_TO_AREA;
      end else if (sel < 95) begin
        r.opcode = OP_WRITE_EXTENT;
        if ($urandom_range(3) == 0) r.extent_length = '0;
      end else begin
        r.opcode = OP_UNUSED;
      end
      drive_request(r, 1'b0, '0);
    end
  endtask

  // Result side: random stalls and a check of every accepted transaction.
  always @(posedge clk) begin : rsp_check
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_translations.size() == 0) begin
        report_mismatch("result with nothing outstanding", rsp.translated_block, '0);
      end else begin
        want = pending_translations.pop_front();
        if (rsp.translated_block !== want.translated_block) begin
          report_mismatch("translated_block", rsp.translated_block, want.translated_block);
        end
        if (rsp.used_fallback !== want.used_fallback) begin
          report_mismatch("used_fallback", 32'(rsp.used_fallback),
                          32'(want.used_fallback));
        end
      end
    end
    rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
  end

  initial begin
    step_t directed[$];
    cfg_t  corner [5];
    foreach (extent_base[i]) begin
      extent_base[i] = '0;
      extent_span[i] = '0;
    end

    // Settings at the edges of the register ranges.
    corner[0] = make_setting(1'b0, 24, 24, 32'hFFFF_FFFF);
    corner[1] = make_setting(1'b0, 9, 1, 32'h0);
    corner[2] = make_setting(1'b1, 9, 0, 32'h0);
    corner[3] = make_setting(1'b0, 24, 1, 32'h8000_0000);
    corner[4] = make_setting(1'b0, 9, 24, 32'hFFFF_FFFF);

    // Direct mapping straight after reset, then with a header base and wrap.
    directed.push_back(checked_step(OP_AREA_TO_PHYS, 32'h0, 32'h0, 1'b0));
    directed.push_back(checked_step(OP_AREA_TO_PHYS, 32'hFFFF_FFFF, 32'hFFFF_FFF8, 1'b0));
    directed.push_back(checked_step(OP_PHYS_TO_AREA, 32'hFFFF_FFFF, 32'h1FFF_FFFF, 1'b0));
    directed.push_back(request_step(OP_UNUSED, 32'hA5A5_A5A5, 3'd5, '1, '1));
    directed.push_back(setting_step(make_setting(1'b0, 12, 0, 32'h1000)));
    directed.push_back(checked_step(OP_AREA_TO_PHYS, 32'h1, 32'h1008, 1'b0));
    directed.push_back(checked_step(OP_PHYS_TO_AREA, 32'h0, 32'h1FFF_FE00, 1'b0));
    // Root mode ignores the base.
    directed.push_back(setting_step(make_setting(1'b1, 24, 0, 32'hFFFF_FFFF)));
    directed.push_back(checked_step(OP_AREA_TO_PHYS, 32'h1, 32'h8000, 1'b0));
    directed.push_back(checked_step(OP_PHYS_TO_AREA, 32'hFFFF_FFFF, 32'h1_FFFF, 1'b0));
    // A fragment size with an empty table still maps directly.
    directed.push_back(setting_step(make_setting(1'b0, 12, 12, 32'h1000)));
    directed.push_back(checked_step(OP_AREA_TO_PHYS, 32'h3, 32'h1018, 1'b0));
    // Two extents, the second so long that its end wraps; the last slot lies beyond.
    directed.push_back(request_step(OP_WRITE_EXTENT, '0, 3'd0, 32'h100, 32'h4));
    directed.push_back(request_step(OP_WRITE_EXTENT, '1, 3'd1, 32'h400, 32'hFFFF_FFFF));
    directed.push_back(request_step(OP_WRITE_EXTENT, '0, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    directed.push_back(request_step(OP_AREA_TO_PHYS, 32'h2, '0, '0, '0));
    directed.push_back(request_step(OP_AREA_TO_PHYS, 32'h5, '1, '1, '1));
    directed.push_back(request_step(OP_PHYS_TO_AREA, 32'h810, '0, '0, '0));
    directed.push_back(request_step(OP_PHYS_TO_AREA, 32'h0, '1, '1, '1));
    // Area and fragment blocks both smaller than a physical block.
    directed.push_back(setting_step(make_setting(1'b0, 4, 6, 32'h80)));
    directed.push_back(request_step(OP_AREA_TO_PHYS, 32'hFFFF_FFFF, '0, '0, '0));
    directed.push_back(request_step(OP_PHYS_TO_AREA, 32'h40, '0, '0, '0));
    // Fragment blocks larger than area blocks.
    directed.push_back(setting_step(make_setting(1'b0, 9, 24, 32'h0)));
    directed.push_back(request_step(OP_AREA_TO_PHYS, 32'h1_2345, '0, '0, '0));
    directed.push_back(request_step(OP_PHYS_TO_AREA, 32'h2_0000, '0, '0, '0));

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[k]) begin
      if (directed[k].is_setting) begin
        settle();
        program_registers(directed[k].setting);
      end else begin
        drive_request(directed[k].r, directed[k].typed, directed[k].want);
      end
    end

    // Three idling patterns, five blocks each.
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          req_idle_pct = 38;
          rsp_idle_pct = 88;
        end
        1: begin
          req_idle_pct = 88;
          rsp_idle_pct = 38;
        end
        default: begin
          req_idle_pct = 0;
          rsp_idle_pct = 0;
        end
      endcase
      for (int b = 0; b < 5; b++) begin
        if (b < 2 && 2 * ph + b < 5) run_block(corner[2 * ph + b]);
        else run_block(random_setting());
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("[fragment_extent_translator_core] OK");
    end else begin
      $display("[fragment_extent_translator_core] ERROR");
    end
    $finish;
  end

endmodule
